// File: sv/block_chain_allocation_table_core_assert.svh
// Assertion macros shared by the RTL files.
`ifndef BLOCK_CHAIN_ALLOCATION_TABLE_CORE_ASSERT_SVH
`define BLOCK_CHAIN_ALLOCATION_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BCAT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define BCAT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCAT_ASSERT_IMP(label, clk, rstn, ante, cons, msg)

`define BCAT_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/bcat_pkg.sv
package bcat_pkg;

    localparam int NUM_BLOCKS_DEF = 256;

    typedef enum logic [1:0] {
        TAG_FREE = 2'd0,
        TAG_RSVD = 2'd1,
        TAG_END  = 2'd2,
        TAG_LINK = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_EXTEND = 2'd1,
        FUNC_SEEK   = 2'd2,
        FUNC_FREE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_HEAD,
        CUR_INC,
        CUR_NEXT
    } cur_op_t;

    typedef enum logic [1:0] {
        RES_CUR,
        RES_HEAD,
        RES_FBLK,
        RES_ZERO
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        cur_op_t  cur_op;
        logic     n_clr;
        logic     n_inc;
        logic     fblk_load;
        logic     wr_en;
        tag_t     wr_tag;
        logic     res_load;
        res_sel_t res_sel;
        logic     res_full;
        logic     out_load;
    } bcat_cmd_t;

    typedef struct packed {
        func_t func;
        tag_t  tag;
        logic  cur_last;
        logic  n_below_total;
        logic  n_below_steps;
        logic  n_last;
        logic  head_ok;
        logic  head_is_cur;
        logic  out_free;
    } bcat_stat_t;

endpackage

// File: sv/bcat_datapath.sv
`include "block_chain_allocation_table_core_assert.svh"

module bcat_datapath #(
    parameter int NUM_BLOCKS = bcat_pkg::NUM_BLOCKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bcat_pkg::bcat_cmd_t   cmd,
    output bcat_pkg::bcat_stat_t  stat,
    input  logic [15:0]           s_tdata,   // head_block[7:0], step_count[15:8]
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // block_index[7:0]
    output logic                  m_tuser    // status[0]
);
    import bcat_pkg::*;

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int NW = IW + 1;
    localparam int EW = IW + 2;

    logic [EW-1:0] mem [NUM_BLOCKS];
    logic [EW-1:0] rd_reg;

    logic [IW-1:0] cur_reg, cur_next;
    logic [NW-1:0] n_reg;
    logic [IW-1:0] fblk_reg;
    func_t         func_reg;
    logic [7:0]    head_reg;
    logic [7:0]    steps_reg;
    logic [7:0]    res_reg;
    logic          full_reg;
    logic          m_valid_reg;
    logic [7:0]    m_data_reg;
    logic          m_status_reg;

    logic [IW-1:0] rd_next;
    logic [IW-1:0] wr_next;
    logic [7:0]    res_next;

    assign rd_next = rd_reg[IW-1:0];
    assign wr_next = (cmd.wr_tag == TAG_LINK) ? fblk_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cur_reg] <= {cmd.wr_tag, wr_next};
        end
        rd_reg <= mem[cur_reg];
    end

    always_comb begin
        case (cmd.cur_op)
            CUR_ZERO: cur_next = '0;
            CUR_HEAD: cur_next = IW'(head_reg);
            CUR_INC:  cur_next = cur_reg + IW'(1);
            CUR_NEXT: cur_next = rd_next;
            default:  cur_next = cur_reg;
        endcase
    end

    always_comb begin
        case (cmd.res_sel)
            RES_CUR:  res_next = 8'(cur_reg);
            RES_HEAD: res_next = head_reg;
            RES_FBLK: res_next = 8'(fblk_reg);
            default:  res_next = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg <= cur_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= func_t'(s_tuser);
            head_reg  <= s_tdata[7:0];
            steps_reg <= s_tdata[15:8];
        end
        if (cmd.n_clr) begin
            n_reg <= '0;
        end else if (cmd.n_inc) begin
            n_reg <= n_reg + NW'(1);
        end
        if (cmd.fblk_load) begin
            fblk_reg <= cur_reg;
        end
        if (cmd.res_load) begin
            res_reg  <= res_next;
            full_reg <= cmd.res_full;
        end
        if (cmd.out_load) begin
            m_data_reg   <= res_reg;
            m_status_reg <= full_reg;
        end
    end

    assign stat.func          = func_reg;
    assign stat.tag           = tag_t'(rd_reg[EW-1 -: 2]);
    assign stat.cur_last      = (cur_reg == IW'(NUM_BLOCKS - 1));
    assign stat.n_below_total = (32'(n_reg) < 32'(NUM_BLOCKS));
    assign stat.n_below_steps = (32'(n_reg) < 32'(steps_reg));
    assign stat.n_last        = (32'(n_reg) == 32'(NUM_BLOCKS - 1));
    assign stat.head_ok       = (32'(head_reg) < 32'(NUM_BLOCKS));
    assign stat.head_is_cur   = (IW'(head_reg) == cur_reg);
    assign stat.out_free      = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `BCAT_ASSERT_IMP(a_full_zero_index, aclk, aresetn, m_valid_reg && m_status_reg, m_data_reg == 8'd0, "full result with nonzero index")
    `BCAT_ASSERT_NXT(a_out_held, aclk, aresetn, m_valid_reg && !m_tready && !cmd.out_load, m_valid_reg, "result dropped while stalled")
    `BCAT_ASSERT_IMP(a_link_target_in_table, aclk, aresetn, cmd.wr_en && cmd.wr_tag == TAG_LINK, 32'(fblk_reg) < 32'(NUM_BLOCKS), "link target outside table")

endmodule

// File: sv/bcat_ctrl.sv
`include "block_chain_allocation_table_core_assert.svh"

module bcat_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bcat_pkg::bcat_stat_t  stat,
    output bcat_pkg::bcat_cmd_t   cmd
);
    import bcat_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_EXT_RD,
        ST_EXT_EV,
        ST_SEEK_RD,
        ST_SEEK_EV,
        ST_FREE_RD,
        ST_FREE_EV,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.cur_op    = CUR_HOLD;
        cmd.wr_tag    = TAG_FREE;
        cmd.res_sel   = RES_ZERO;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_tag = TAG_FREE;
                if (stat.cur_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.cur_op = CUR_INC;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.func)
                    FUNC_ALLOC, FUNC_EXTEND: begin
                        cmd.cur_op = CUR_ZERO;
                        state_next = ST_SCAN_RD;
                    end
                    FUNC_SEEK: begin
                        if (stat.head_ok) begin
                            cmd.cur_op = CUR_HEAD;
                            cmd.n_clr  = 1'b1;
                            state_next = ST_SEEK_RD;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_HEAD;
                            state_next   = ST_RESP;
                        end
                    end
                    default: begin
                        if (stat.head_ok) begin
                            cmd.cur_op = CUR_HEAD;
                            cmd.n_clr  = 1'b1;
                            state_next = ST_FREE_RD;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                            state_next   = ST_RESP;
                        end
                    end
                endcase
            end
            ST_SCAN_RD: state_next = ST_SCAN_EV;
            ST_SCAN_EV: begin
                if (stat.tag == TAG_FREE) begin
                    cmd.wr_en     = 1'b1;
                    cmd.fblk_load = 1'b1;
                    if (stat.func == FUNC_ALLOC) begin
                        cmd.wr_tag   = TAG_RSVD;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_CUR;
                        state_next   = ST_RESP;
                    end else begin
                        cmd.wr_tag = TAG_END;
                        if (stat.head_ok && !stat.head_is_cur) begin
                            cmd.cur_op = CUR_HEAD;
                            cmd.n_clr  = 1'b1;
                            state_next = ST_EXT_RD;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_CUR;
                            state_next   = ST_RESP;
                        end
                    end
                end else if (stat.cur_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                    cmd.res_full = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.cur_op = CUR_INC;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EXT_RD: state_next = ST_EXT_EV;
            ST_EXT_EV: begin
                if (stat.n_below_total && stat.tag == TAG_LINK) begin
                    cmd.cur_op = CUR_NEXT;
                    cmd.n_inc  = 1'b1;
                    state_next = ST_EXT_RD;
                end else begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_tag   = TAG_LINK;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FBLK;
                    state_next   = ST_RESP;
                end
            end
            ST_SEEK_RD: state_next = ST_SEEK_EV;
            ST_SEEK_EV: begin
                if (stat.n_below_steps && stat.n_below_total && stat.tag == TAG_LINK) begin
                    cmd.cur_op = CUR_NEXT;
                    cmd.n_inc  = 1'b1;
                    state_next = ST_SEEK_RD;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_CUR;
                    state_next   = ST_RESP;
                end
            end
            ST_FREE_RD: state_next = ST_FREE_EV;
            ST_FREE_EV: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_tag = TAG_FREE;
                if (stat.tag == TAG_LINK && !stat.n_last) begin
                    cmd.cur_op = CUR_NEXT;
                    cmd.n_inc  = 1'b1;
                    state_next = ST_FREE_RD;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    `BCAT_ASSERT_IMP(a_load_needs_slot, aclk, aresetn, cmd.out_load, stat.out_free, "output loaded while occupied")
    `BCAT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    `BCAT_ASSERT_IMP(a_seek_read_only, aclk, aresetn, state_reg == ST_SEEK_RD || state_reg == ST_SEEK_EV, !cmd.wr_en, "table written during seek")

endmodule

// File: sv/block_chain_allocation_table_core.sv
// A request walks the table entry by entry (free-block scan and extend, seek or free
// walks) between request accept and m_tvalid.
// Throughput: one request at a time; the next is taken once the result is registered.
// Walk speed is set by the single table read port: each entry is read (registered read), then evaluated.
// Reset: synchronous active low; a clearing pass marks every entry free, and no
// request is taken until it completes.
module block_chain_allocation_table_core #(
    parameter int NUM_BLOCKS = bcat_pkg::NUM_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // head_block[7:0], step_count[15:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // block_index[7:0]
    output logic        m_tuser    // status[0]
);
    import bcat_pkg::*;

    bcat_cmd_t  cmd;
    bcat_stat_t stat;

    bcat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcat_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
